@@ rtl/bcrf_pkg.sv @@
package bcrf_pkg;

    localparam int LINES_DEF = 4;
    localparam int DEPTH_DEF = 256;

    typedef logic [7:0] t_byte;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

    // Registers sit on a 4-byte pitch, so paddr[2] selects between them.
    typedef enum logic {
        REG_RING_SIZE = 1'b0,
        REG_OPEN_MASK = 1'b1
    } t_reg;

    localparam logic [8:0] RING_SIZE_RESET = 9'd256;
    localparam logic [3:0] OPEN_MASK_RESET = 4'hF;
    localparam logic [2:0] TAKEN_MAX       = 3'd7;

endpackage

@@ rtl/bcrf_bank.sv @@
module bcrf_bank #(
    parameter int DEPTH = bcrf_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  bcrf_pkg::t_byte            i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output bcrf_pkg::t_byte            o_rd_data
);

    bcrf_pkg::t_byte r_mem [DEPTH];
    bcrf_pkg::t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read register only moves on a pop, so a stalled result keeps its byte.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/broadcast_ring_fifo.sv @@
// Broadcast ring FIFO: LINES byte rings, each with its own bank of DEPTH bytes. A write item
// offers its byte to every open line that is not full and reports how many lines took it; a
// read item pops the oldest byte of one line. One item is accepted per cycle unless the input
// stalls; its result comes out of the result register (with the banks' registered read data),
// which follows the input register and a single pass of pointer logic. Writing ring_size
// re-reduces every stored line position modulo the new size with a bit-serial remainder lane
// per pointer, which keeps the input stalled until the lanes have run over every position bit.
module broadcast_ring_fifo #(
    parameter int LINES = bcrf_pkg::LINES_DEF,
    parameter int DEPTH = bcrf_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [0:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic [1:0]  i_line_index,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_taken_count,
    output logic [7:0]  o_read_byte,
    output logic [0:0]  o_read_valid,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(DEPTH);
    localparam int SW = IW + 1;
    localparam int ZW = (SW > 9) ? SW : 9;
    localparam int CW = $clog2(LINES + 1);
    localparam int NW = $clog2(IW + 1);

    // Configuration registers
    logic [8:0]  r_ring_size;
    logic [3:0]  r_open_mask;
    logic        w_cfg_wr;
    logic        w_ring_wr;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_ring_wr = w_cfg_wr && (paddr[2] == bcrf_pkg::REG_RING_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= bcrf_pkg::RING_SIZE_RESET;
            r_open_mask <= bcrf_pkg::OPEN_MASK_RESET;
        end else if (w_cfg_wr) begin
            unique case (bcrf_pkg::t_reg'(paddr[2]))
                bcrf_pkg::REG_RING_SIZE: r_ring_size <= pwdata[8:0];
                bcrf_pkg::REG_OPEN_MASK: r_open_mask <= pwdata[3:0];
            endcase
        end
    end

    always_comb begin
        unique case (bcrf_pkg::t_reg'(paddr[2]))
            bcrf_pkg::REG_RING_SIZE: prdata = 32'(r_ring_size);
            bcrf_pkg::REG_OPEN_MASK: prdata = 32'(r_open_mask);
        endcase
    end

    // Ring length in use: zero counts as one, anything above the bank depth as the depth.
    logic [ZW-1:0] w_rs_ext;
    logic [SW-1:0] w_eff;
    logic [SW-1:0] w_cap;

    assign w_rs_ext = ZW'(r_ring_size);

    always_comb begin
        priority if (r_ring_size == 9'd0) begin
            w_eff = SW'(1);
        end else if (w_rs_ext > ZW'(DEPTH)) begin
            w_eff = SW'(DEPTH);
        end else begin
            w_eff = SW'(w_rs_ext);
        end
    end

    assign w_cap = w_eff - SW'(1);

    // Position reduction sequencer
    logic          r_norm_busy;
    logic [NW-1:0] r_norm_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_busy <= 1'b0;
            r_norm_cnt  <= '0;
        end else if (w_ring_wr) begin
            r_norm_busy <= 1'b1;
            r_norm_cnt  <= '0;
        end else if (r_norm_busy) begin
            r_norm_cnt <= r_norm_cnt + NW'(1);
            if (r_norm_cnt == NW'(IW - 1)) begin
                r_norm_busy <= 1'b0;
            end
        end
    end

    // Input register
    logic             r_a_valid;
    bcrf_pkg::t_cmd   r_a_cmd;
    bcrf_pkg::t_byte  r_a_data;
    logic [1:0]       r_a_line;

    // Result register
    logic             r_b_valid;
    logic [2:0]       r_b_taken;
    logic [LINES-1:0] r_b_pop;

    logic             w_adv;
    logic             w_in_acc;
    logic             w_do_wr;
    logic             w_do_rd;

    assign w_adv    = r_a_valid && !r_norm_busy && (!r_b_valid || !i_out_stall);
    assign o_in_stall = r_norm_busy || (r_a_valid && !w_adv);
    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_do_wr  = w_adv && (r_a_cmd == bcrf_pkg::CMD_WRITE);
    assign w_do_rd  = w_adv && (r_a_cmd == bcrf_pkg::CMD_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_a_valid <= 1'b1;
        end else if (w_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_cmd  <= bcrf_pkg::t_cmd'(i_command);
            r_a_data <= i_data_byte;
            r_a_line <= i_line_index;
        end
    end

    // Per-line pointers and banks
    logic [LINES-1:0] w_take;
    logic [LINES-1:0] w_pop;
    bcrf_pkg::t_byte  w_q [LINES];

    for (genvar g = 0; g < LINES; g++) begin : g_line
        logic          r_wr_raw;
        logic [IW-1:0] r_wr_raw_v;
        logic [IW-1:0] r_wr_pos;
        logic [IW-1:0] r_rd_raw_v;
        logic [IW-1:0] r_rd_pos;
        logic [IW-1:0] r_wr_sh;
        logic [IW-1:0] r_rd_sh;
        logic [IW-1:0] r_fill;
        logic          w_open;
        logic          w_full;
        logic [SW-1:0] w_wr_inc;
        logic [SW-1:0] w_rd_inc;
        logic [IW-1:0] n_wr_pos;
        logic [IW-1:0] n_rd_pos;
        logic [SW-1:0] w_wr_t;
        logic [SW-1:0] w_rd_t;
        logic [IW-1:0] n_wr_rem;
        logic [IW-1:0] n_rd_rem;

        if (g < 4) begin : g_open
            assign w_open = r_open_mask[g];
        end else begin : g_closed
            assign w_open = 1'b0;
        end

        assign w_full    = SW'(r_fill) >= w_cap;
        assign w_take[g] = w_do_wr && w_open && !w_full;
        assign w_pop[g]  = w_do_rd && (32'(r_a_line) == 32'(g)) && (r_fill != '0);

        assign w_wr_inc = SW'(r_wr_pos) + SW'(1);
        assign w_rd_inc = SW'(r_rd_pos) + SW'(1);
        assign n_wr_pos = (w_wr_inc == w_eff) ? '0 : IW'(w_wr_inc);
        assign n_rd_pos = (w_rd_inc == w_eff) ? '0 : IW'(w_rd_inc);

        // One restoring step of raw position modulo the ring length, MSB first.
        assign w_wr_t   = {r_wr_pos, r_wr_sh[IW-1]};
        assign w_rd_t   = {r_rd_pos, r_rd_sh[IW-1]};
        assign n_wr_rem = (w_wr_t >= w_eff) ? IW'(w_wr_t - w_eff) : IW'(w_wr_t);
        assign n_rd_rem = (w_rd_t >= w_eff) ? IW'(w_rd_t - w_eff) : IW'(w_rd_t);

        // The raw positions keep what each pointer held before any later size change,
        // because each reduction after a ring_size write starts again from these raw values.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_wr_raw_v <= '0;
                r_wr_pos   <= '0;
                r_rd_raw_v <= '0;
                r_rd_pos   <= '0;
                r_fill     <= '0;
                r_wr_sh    <= '0;
                r_rd_sh    <= '0;
            end else if (w_ring_wr) begin
                r_wr_pos <= '0;
                r_rd_pos <= '0;
                r_wr_sh  <= r_wr_raw_v;
                r_rd_sh  <= r_rd_raw_v;
            end else if (r_norm_busy) begin
                r_wr_pos <= n_wr_rem;
                r_rd_pos <= n_rd_rem;
                r_wr_sh  <= r_wr_sh << 1;
                r_rd_sh  <= r_rd_sh << 1;
            end else begin
                if (w_take[g]) begin
                    r_wr_pos   <= n_wr_pos;
                    r_wr_raw_v <= n_wr_pos;
                    r_fill     <= r_fill + IW'(1);
                end
                if (w_pop[g]) begin
                    r_rd_pos   <= n_rd_pos;
                    r_rd_raw_v <= n_rd_pos;
                    r_fill     <= r_fill - IW'(1);
                end
            end
        end

        // Flag kept for the line having taken at least one byte since reset.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_wr_raw <= 1'b0;
            end else if (w_take[g]) begin
                r_wr_raw <= 1'b1;
            end
        end

        bcrf_bank #(
            .DEPTH (DEPTH)
        ) u_bank (
            .i_clk     (i_clk),
            .i_wr_en   (w_take[g]),
            .i_wr_addr (r_wr_pos),
            .i_wr_data (r_a_data),
            .i_rd_en   (w_pop[g]),
            .i_rd_addr (r_rd_pos),
            .o_rd_data (w_q[g])
        );
    end

    logic [CW-1:0] w_take_cnt;
    logic [2:0]    w_taken_sat;

    assign w_take_cnt  = CW'($countones(w_take));
    assign w_taken_sat = (32'(w_take_cnt) > 32'(bcrf_pkg::TAKEN_MAX)) ?
                         bcrf_pkg::TAKEN_MAX : 3'(w_take_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_taken <= w_taken_sat;
            r_b_pop   <= w_pop;
        end
    end

    bcrf_pkg::t_byte w_rbyte;

    always_comb begin
        w_rbyte = '0;
        for (int k = 0; k < LINES; k++) begin
            w_rbyte = w_rbyte | (r_b_pop[k] ? w_q[k] : 8'd0);
        end
    end

    assign o_out_valid   = r_b_valid;
    assign o_taken_count = r_b_taken;
    assign o_read_byte   = w_rbyte;
    assign o_read_valid  = |r_b_pop;

    // A line that has never taken a byte cannot have anything to pop.
    logic [LINES-1:0] w_never_written;

    for (genvar g = 0; g < LINES; g++) begin : g_chk
        assign w_never_written[g] = !g_line[g].r_wr_raw;
    end

    a_one_kind_of_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_read_valid && (o_taken_count != 3'd0)))
        else $error("result carries both a taken count and a popped byte");

    a_single_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_pop))
        else $error("more than one line popped by one item");

    a_no_work_while_reducing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_norm_busy |-> (!w_adv && o_in_stall))
        else $error("item processed while line positions are being reduced");

    a_reduce_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ring_wr |=> (r_norm_busy && (r_norm_cnt == '0)))
        else $error("ring size write did not restart position reduction");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop & w_never_written) == '0)
        else $error("pop from a line that never stored a byte");

endmodule

@@ bench/broadcast_ring_fifo_tb.sv @@
module broadcast_ring_fifo_tb;

    import bcrf_pkg::*;

    localparam int LINES        = LINES_DEF;
    localparam int DEPTH        = DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [2:0] taken;
        t_byte      rbyte;
        logic       rvalid;
    } t_fifo_result;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_cmd       cmd;
        t_byte      data;
        logic [1:0] line;
        t_reg       sel;
        logic [8:0] value;
        logic       checked;
        logic [2:0] want_taken;
        t_byte      want_byte;
        logic       want_valid;
    } t_step_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [0:0]  i_command = CMD_WRITE;
    logic [7:0]  i_data_byte = 8'h00;
    logic [1:0]  i_line_index = 2'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_taken_count;
    logic [7:0]  o_read_byte;
    logic [0:0]  o_read_valid;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Own copy of the rings, positions and register settings.
    t_byte      ring_mem [LINES][DEPTH];
    logic [7:0] wr_ptr [LINES] = '{default: 8'd0};
    logic [7:0] rd_ptr [LINES] = '{default: 8'd0};
    logic [7:0] line_fill [LINES] = '{default: 8'd0};
    logic [8:0] cfg_ring_size = RING_SIZE_RESET;
    logic [3:0] cfg_open_mask = OPEN_MASK_RESET;

    t_fifo_result expected_results [$];
    t_step_row    directed_rows [$];

    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    int n_errors = 0;
    int n_items = 0;
    int n_pops = 0;
    int n_refused = 0;
    int n_reg_writes = 0;
    int cycle_count = 0;

    broadcast_ring_fifo u_top (.*);

    always #2 i_clk = ~i_clk;

    function automatic int unsigned ring_len();
        if (cfg_ring_size == 9'd0) begin
            return 1;
        end
        if (cfg_ring_size > 9'(DEPTH)) begin
            return DEPTH;
        end
        return int'(cfg_ring_size);
    endfunction

    // Applies one item to the model state and returns the result it should produce.
    function automatic t_fifo_result fifo_step(input t_cmd cmd, input t_byte data,
                                               input logic [1:0] line);
        t_fifo_result res;
        int unsigned  len;
        int unsigned  pos;
        res = '0;
        len = ring_len();
        if (cmd == CMD_WRITE) begin
            for (int i = 0; i < LINES; i++) begin
                if (cfg_open_mask[i]) begin
                    // A line is full once its fill reaches the capacity, or has passed it
                    // after the ring was shortened.
                    if (int'(line_fill[i]) >= int'(len) - 1) begin
                        n_refused++;
                    end else begin
                        pos = wr_ptr[i] % len;
                        ring_mem[i][pos] = data;
                        wr_ptr[i] = 8'((pos + 1) % len);
                        line_fill[i] = line_fill[i] + 8'd1;
                        res.taken = res.taken + 3'd1;
                    end
                end
            end
        end else if (line_fill[line] != 8'd0) begin
            pos = rd_ptr[line] % len;
            res.rbyte = ring_mem[line][pos];
            res.rvalid = 1'b1;
            rd_ptr[line] = 8'((pos + 1) % len);
            line_fill[line] = line_fill[line] - 8'd1;
            n_pops++;
        end
        return res;
    endfunction

    task automatic send_item(input t_cmd cmd, input t_byte data, input logic [1:0] line,
                             input logic typed, input t_fifo_result typed_res);
        t_fifo_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_data_byte  <= data;
        i_line_index <= line;
        do @(posedge i_clk); while (o_in_stall);
        res = fifo_step(cmd, data, line);
        expected_results.push_back(typed ? typed_res : res);
        n_items++;
    endtask

    // Waits for the block to go quiet, writes a register and reads it back.
    task automatic write_register(input t_reg sel, input logic [8:0] value);
        logic [31:0] readback;
        logic [31:0] stored;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_RING_SIZE) begin
            cfg_ring_size = value;
            stored = 32'(value);
        end else begin
            cfg_open_mask = value[3:0];
            stored = 32'(value[3:0]);
        end
        n_reg_writes++;
        if (readback !== stored) begin
            $error("register %s: expected %0d, got %0d", sel.name(), stored, readback);
            n_errors++;
        end
    endtask

    task automatic drain_lines();
        for (int l = 0; l < LINES; l++) begin
            while (line_fill[l] != 8'd0) begin
                send_item(CMD_READ, 8'($urandom), 2'(l), 1'b0, '0);
            end
        end
    endtask

    // The ring size only changes with every line empty, so that read and write
    // positions stay in step whatever size follows.
    task automatic run_round(input logic [8:0] size, input logic [3:0] mask, input int count,
                             input int unsigned write_pct);
        if (size != cfg_ring_size) begin
            drain_lines();
        end
        write_register(REG_RING_SIZE, size);
        write_register(REG_OPEN_MASK, 9'(mask));
        repeat (count) begin
            if ($urandom_range(99) < write_pct) begin
                send_item(CMD_WRITE, 8'($urandom), 2'($urandom), 1'b0, '0);
            end else begin
                send_item(CMD_READ, 8'($urandom), 2'($urandom), 1'b0, '0);
            end
        end
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_fifo_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result arrived with no item outstanding");
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_taken_count !== want.taken) begin
                    $error("taken_count: expected %0d, got %0d", want.taken, o_taken_count);
                    n_errors++;
                end
                if (o_read_byte !== want.rbyte) begin
                    $error("read_byte: expected %02h, got %02h", want.rbyte, o_read_byte);
                    n_errors++;
                end
                if (o_read_valid !== want.rvalid) begin
                    $error("read_valid: expected %0d, got %0d", want.rvalid, o_read_valid);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("run did not complete within %0d cycles", CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        t_step_row    row;
        t_fifo_result want;

        directed_rows = '{
            // Empty line straight after reset, then both byte extremes to every line.
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd0, REG_RING_SIZE, 9'd0,   1'b1, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_WRITE, 8'h00, 2'd0, REG_RING_SIZE, 9'd0,   1'b1, 3'd4, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_WRITE, 8'hFF, 2'd1, REG_RING_SIZE, 9'd0,   1'b1, 3'd4, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd3, REG_RING_SIZE, 9'd0,   1'b1, 3'd0, 8'h00, 1'b1},
            '{ROW_ITEM, CMD_READ,  8'hFF, 2'd3, REG_RING_SIZE, 9'd0,   1'b1, 3'd0, 8'hFF, 1'b1},
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd3, REG_RING_SIZE, 9'd0,   1'b1, 3'd0, 8'h00, 1'b0},
            // Every line closed, then only lines 0 and 2 open.
            '{ROW_REG,  CMD_WRITE, 8'h00, 2'd0, REG_OPEN_MASK, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_WRITE, 8'hA5, 2'd2, REG_RING_SIZE, 9'd0,   1'b1, 3'd0, 8'h00, 1'b0},
            '{ROW_REG,  CMD_WRITE, 8'h00, 2'd0, REG_OPEN_MASK, 9'd5,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_WRITE, 8'h5A, 2'd3, REG_RING_SIZE, 9'd0,   1'b1, 3'd2, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h7E, 2'd1, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h81, 2'd1, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd1, REG_RING_SIZE, 9'd0,   1'b1, 3'd0, 8'h00, 1'b0},
            // Shorten the ring while lines 0 and 2 hold three bytes each.
            '{ROW_REG,  CMD_WRITE, 8'h00, 2'd0, REG_RING_SIZE, 9'd2,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_WRITE, 8'h3C, 2'd0, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd0, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd0, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd0, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd2, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd2, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd2, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            // One byte through lines 0 and 2 brings their positions back in step.
            '{ROW_ITEM, CMD_WRITE, 8'hC3, 2'd0, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd0, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd2, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            // A ring size of zero behaves as one, so nothing can be stored.
            '{ROW_REG,  CMD_WRITE, 8'h00, 2'd0, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_WRITE, 8'h81, 2'd0, REG_RING_SIZE, 9'd0,   1'b1, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd2, REG_RING_SIZE, 9'd0,   1'b1, 3'd0, 8'h00, 1'b0},
            // A size beyond the bank depth is held at the depth.
            '{ROW_REG,  CMD_WRITE, 8'h00, 2'd0, REG_RING_SIZE, 9'd511, 1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_REG,  CMD_WRITE, 8'h00, 2'd0, REG_OPEN_MASK, 9'd15,  1'b0, 3'd0, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_WRITE, 8'h7F, 2'd0, REG_RING_SIZE, 9'd0,   1'b1, 3'd4, 8'h00, 1'b0},
            '{ROW_ITEM, CMD_READ,  8'h00, 2'd1, REG_RING_SIZE, 9'd0,   1'b0, 3'd0, 8'h00, 1'b0}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct = 24;
        recv_stall_pct = 49;

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_REG) begin
                write_register(row.sel, row.value);
            end else begin
                want = '{row.want_taken, row.want_byte, row.want_valid};
                send_item(row.cmd, row.data, row.line, row.checked, want);
            end
        end

        // Nearly all writes into line 0 alone, so that it fills to the held capacity.
        run_round(9'd511, 4'b0001, 280, 98);
        run_round(9'd3,   4'b1111, 70,  55);
        run_round(9'd1,   4'b1001, 40,  50);

        send_gap_pct = 49;
        recv_stall_pct = 24;
        run_round(9'd256, 4'b0110, 60,  60);
        run_round(9'd2,   4'b1111, 50,  50);
        run_round(9'd17,  4'b0011, 60,  55);

        send_gap_pct = 0;
        recv_stall_pct = 0;
        run_round(9'd128, 4'b1100, 50,  55);
        run_round(9'd5,   4'b1111, 50,  50);
        run_round(9'd64,  4'b1011, 40,  55);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items, %0d bytes popped and %0d writes refused by full lines,",
                 n_items, n_pops, n_refused);
        $display("across %0d register writes and %0d clock cycles.", n_reg_writes, cycle_count);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
